// File: rtl/core/ycbcr_8x8_block_former_core_defines.svh
// Assertion macros shared by the block former RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef YCBCR_8X8_BLOCK_FORMER_CORE_DEFINES_SVH
`define YCBCR_8X8_BLOCK_FORMER_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define YBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define YBF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/ybf_pkg.sv
// Shared types and constants of the YCbCr 8x8 block former.
// No dependencies; used by ybf_ctrl, ybf_datapath and the top level.
`default_nettype none

package ybf_pkg;

  // Register widths and indexes
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

  // Stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // Block geometry
  localparam logic [5:0] LAST_SAMPLE = 6'd63;
  localparam logic [2:0] LAST_OFFSET = 3'd7;

  // JFIF conversion coefficients, 16 fraction bits
  localparam int ACC_W = 26;
  localparam logic signed [ACC_W-1:0] Y_R  =  26'sd19595;
  localparam logic signed [ACC_W-1:0] Y_G  =  26'sd38470;
  localparam logic signed [ACC_W-1:0] Y_B  =  26'sd7471;
  localparam logic signed [ACC_W-1:0] CB_R = -26'sd11056;
  localparam logic signed [ACC_W-1:0] CB_G = -26'sd21712;
  localparam logic signed [ACC_W-1:0] CB_B =  26'sd32768;
  localparam logic signed [ACC_W-1:0] CR_R =  26'sd32768;
  localparam logic signed [ACC_W-1:0] CR_G = -26'sd27440;
  localparam logic signed [ACC_W-1:0] CR_B = -26'sd5328;
  localparam logic signed [ACC_W-1:0] CHROMA_OFS = 26'sd8388608;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the incoming item
    logic convert;  // register YCbCr of the latched pixel
    logic commit;   // write band store, step counters, snapshot block
    logic read;     // fetch the current sample of the block
    logic advance;  // step to the next sample
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic block_done;   // committed pixel completes a block
    logic last_sample;  // current sample is the block's last
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ybf_ctrl.sv
// Sequencer of the block former: handshakes and datapath commands.
// Depends on ybf_pkg and the assertion macros header.
`default_nettype none
`include "ycbcr_8x8_block_former_core_defines.svh"

module ybf_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  output ybf_pkg::cmd_t     cmd_o,
  input  wire ybf_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COMMIT,
    ST_READ,
    ST_SHOW
  } state_e;

  state_e state_q;
  logic   s_tready_q;
  logic   m_tvalid_q;
  logic   in_fire;
  logic   out_fire;

  assign in_fire  = s_tvalid_i && s_tready_q;
  assign out_fire = m_tvalid_q && m_tready_i;

  // Commands follow the state
  always_comb begin
    cmd_o         = '0;
    cmd_o.accept  = in_fire;
    cmd_o.convert = (state_q == ST_CONV);
    cmd_o.commit  = (state_q == ST_COMMIT);
    cmd_o.read    = (state_q == ST_READ);
    cmd_o.advance = (state_q == ST_SHOW) && out_fire && !sts_i.last_sample;
  end

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s_tready_q <= 1'b1;
      m_tvalid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q    <= ST_CONV;
            s_tready_q <= 1'b0;
          end
        end
        ST_CONV: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (sts_i.block_done) begin
            state_q <= ST_READ;
          end else begin
            state_q    <= ST_IDLE;
            s_tready_q <= 1'b1;
          end
        end
        ST_READ: begin
          state_q    <= ST_SHOW;
          m_tvalid_q <= 1'b1;
        end
        ST_SHOW: begin
          if (out_fire) begin
            m_tvalid_q <= 1'b0;
            if (sts_i.last_sample) begin
              state_q    <= ST_IDLE;
              s_tready_q <= 1'b1;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          s_tready_q <= 1'b1;
          m_tvalid_q <= 1'b0;
        end
      endcase
    end
  end

  assign s_tready_o = s_tready_q;
  assign m_tvalid_o = m_tvalid_q;

  // Input and output sides never open together
  `YBF_ASSERT_NEVER(a_sides_exclusive, s_tready_q && m_tvalid_q, "input and output both open")
  `YBF_ASSERT(a_accept_converts, in_fire |=> (state_q == ST_CONV), "accepted item not converted")
  `YBF_ASSERT(a_plain_pixel_frees, (state_q == ST_COMMIT && !sts_i.block_done) |=> s_tready_q,
    "pixel without block did not free input")
  `YBF_ASSERT(a_block_end_frees, (state_q == ST_SHOW && out_fire && sts_i.last_sample) |=> s_tready_q,
    "finished block did not free input")

endmodule

`default_nettype wire

// File: rtl/core/ybf_datapath.sv
// Datapath of the block former: size registers, color conversion,
// raster counters, band store and block readout. Depends on ybf_pkg.
`default_nettype none

module ybf_datapath #(
  parameter int MAX_IMAGE_WIDTH  = 2048,
  parameter int MAX_IMAGE_HEIGHT = 4096
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ybf_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [ybf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic [ybf_pkg::IN_DATA_W-1:0]       s_tdata_i,
  input  wire logic                                s_tuser_i,
  input  wire ybf_pkg::cmd_t                       cmd_i,
  output ybf_pkg::sts_t                            sts_o,
  output logic [ybf_pkg::OUT_DATA_W-1:0]           m_tdata_o,
  output logic                                     m_tlast_o,
  output logic                                     m_tuser_o
);

  localparam int CW    = $clog2(MAX_IMAGE_WIDTH);
  localparam int RW    = $clog2(MAX_IMAGE_HEIGHT);
  localparam int DEPTH = 8 * MAX_IMAGE_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int HW    = $clog2(MAX_IMAGE_HEIGHT + 1);
  localparam int WCW   = (WW > ybf_pkg::WIDTH_REG_W) ? WW : ybf_pkg::WIDTH_REG_W;
  localparam int HCW   = (HW > ybf_pkg::HEIGHT_REG_W) ? HW : ybf_pkg::HEIGHT_REG_W;

  // Size registers
  logic [ybf_pkg::WIDTH_REG_W-1:0]  width_q;
  logic [ybf_pkg::HEIGHT_REG_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ybf_pkg::WIDTH_RESET;
      height_q <= ybf_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ybf_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[ybf_pkg::WIDTH_REG_W-1:0];
        ybf_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[ybf_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size: zero acts as one, oversize as the maximum
  logic [WCW-1:0] w_ext;
  logic [HCW-1:0] h_ext;
  logic [CW-1:0]  w_m1;
  logic [RW-1:0]  h_m1;

  always_comb begin
    if (width_q == '0) begin
      w_ext = WCW'(1);
    end else if (WCW'(width_q) > WCW'(MAX_IMAGE_WIDTH)) begin
      w_ext = WCW'(MAX_IMAGE_WIDTH);
    end else begin
      w_ext = WCW'(width_q);
    end
    if (height_q == '0) begin
      h_ext = HCW'(1);
    end else if (HCW'(height_q) > HCW'(MAX_IMAGE_HEIGHT)) begin
      h_ext = HCW'(MAX_IMAGE_HEIGHT);
    end else begin
      h_ext = HCW'(height_q);
    end
  end

  assign w_m1 = CW'(w_ext - WCW'(1));
  assign h_m1 = RW'(h_ext - HCW'(1));

  // Pixel latch and raster position
  logic [ybf_pkg::IN_DATA_W-1:0] rgb_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rgb_q <= s_tdata_i;
    end
  end

  // Color conversion, result registered
  function automatic logic [7:0] to_byte(input logic signed [ybf_pkg::ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[ybf_pkg::ACC_W-1]) begin
      res = 8'd0;
    end else if (acc[ybf_pkg::ACC_W-2:24] != '0) begin
      res = 8'hFF;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

  logic signed [ybf_pkg::ACC_W-1:0] r_s, g_s, b_s;
  logic signed [ybf_pkg::ACC_W-1:0] y_acc, cb_acc, cr_acc;
  logic [23:0] ycc_q;

  always_comb begin
    r_s    = $signed({18'd0, rgb_q[7:0]});
    g_s    = $signed({18'd0, rgb_q[15:8]});
    b_s    = $signed({18'd0, rgb_q[23:16]});
    y_acc  = ybf_pkg::Y_R * r_s + ybf_pkg::Y_G * g_s + ybf_pkg::Y_B * b_s;
    cb_acc = ybf_pkg::CB_R * r_s + ybf_pkg::CB_G * g_s + ybf_pkg::CB_B * b_s
             + ybf_pkg::CHROMA_OFS;
    cr_acc = ybf_pkg::CR_R * r_s + ybf_pkg::CR_G * g_s + ybf_pkg::CR_B * b_s
             + ybf_pkg::CHROMA_OFS;
  end

  // Stored as {Cr, Cb, Y}, luma in the low byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.convert) begin
      ycc_q <= {to_byte(cr_acc), to_byte(cb_acc), to_byte(y_acc)};
    end
  end

  // Edge and block completion tests on the committed pixel
  logic last_col, last_row;
  assign last_col = (col_q >= w_m1);
  assign last_row = (row_q >= h_m1);
  assign sts_o.block_done = (last_col || (col_q[2:0] == ybf_pkg::LAST_OFFSET)) &&
                            (last_row || (row_q[2:0] == ybf_pkg::LAST_OFFSET));

  // Raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept && s_tuser_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.commit) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Snapshot of the block being read out
  logic [CW-1:0] blk_col_q;
  logic [RW-1:0] blk_row_q;
  logic          frame_end_q;
  logic [5:0]    idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      blk_col_q   <= col_q;
      blk_row_q   <= row_q;
      frame_end_q <= last_col && last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.commit) begin
      idx_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + 6'd1;
    end
  end

  assign sts_o.last_sample = (idx_q == ybf_pkg::LAST_SAMPLE);

  // Sample position and padding test
  logic [2:0]    smp_m, smp_n;
  logic [CW-1:0] smp_col;
  logic [RW-1:0] smp_row;
  logic          smp_inside;
  logic [AW-1:0] wr_addr, rd_addr;

  assign smp_m   = idx_q[5:3];
  assign smp_n   = idx_q[2:0];
  assign smp_col = (blk_col_q & ~CW'(7)) | CW'(smp_n);
  assign smp_row = (blk_row_q & ~RW'(7)) | RW'(smp_m);
  assign smp_inside = (smp_m <= blk_row_q[2:0]) && (smp_row <= h_m1) &&
                      (smp_col <= w_m1) &&
                      ({1'b0, smp_col} < (CW + 1)'(MAX_IMAGE_WIDTH));

  assign wr_addr = AW'(row_q[2:0]) * AW'(MAX_IMAGE_WIDTH) + AW'(col_q);
  assign rd_addr = AW'(smp_m) * AW'(MAX_IMAGE_WIDTH) + AW'(smp_col);

  // Band store, eight rows of the widest image
  logic [23:0] band_mem [DEPTH];
  logic [23:0] rd_q;
  logic        inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      band_mem[wr_addr] <= ycc_q;
    end
    if (cmd_i.read && smp_inside) begin
      rd_q <= band_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (cmd_i.read) begin
      inside_q <= smp_inside;
    end
  end

  // Output payload, stable while the sample waits
  logic [CW+7:0]  col_ext;
  logic [RW+8:0]  row_ext;
  logic [23:0]    ycc_out;

  assign col_ext = {8'd0, blk_col_q};
  assign row_ext = {9'd0, blk_row_q};
  assign ycc_out = inside_q ? rd_q : 24'd0;

  assign m_tdata_o = {1'b0, idx_q, row_ext[11:3], col_ext[10:3], ycc_out};
  assign m_tlast_o = sts_o.last_sample;
  assign m_tuser_o = sts_o.last_sample && frame_end_q;

endmodule

`default_nettype wire

// File: rtl/core/ycbcr_8x8_block_former_core.sv
// Top level of the RGB to YCbCr 8x8 block former.
// Instantiates ybf_ctrl and ybf_datapath; depends on ybf_pkg.
//
// Usage:
//   Input stream (s_*): one RGB pixel per item in raster order; tuser marks
//   the first pixel of an image and resets the position to (0,0). The
//   position also wraps to (0,0) after the image's last pixel.
//   Output stream (m_*): 8x8 blocks of YCbCr samples in row-major order,
//   blocks in raster order; positions outside the image read as zero.
//   tlast marks sample 63 of each block, tuser the last sample of the image.
//   Configuration: cfg_we_i writes image_width (index 0) or image_height
//   (index 1); write only while no item is in progress.
// Sequence:
//   A pixel that completes no block is accepted, converted and stored.
//   A pixel that completes a block then adds 64 samples, each read from
//   the band store and then output, and the output may stall; the input
//   is not ready until the block's last sample is taken.
// Reset: counters return to (0,0), both sizes to 512; the band store is not
//   cleared, so no clearing pass is needed. A stalled output holds its sample.
`default_nettype none

module ycbcr_8x8_block_former_core #(
  parameter int MAX_IMAGE_WIDTH  = 2048,
  parameter int MAX_IMAGE_HEIGHT = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input pixels
  input  wire logic                            s_tvalid_i,
  output logic                                 s_tready_o,
  input  wire logic [ybf_pkg::IN_DATA_W-1:0]   s_tdata_i,  // red, green, blue
  input  wire logic                            s_tuser_i,  // start_of_frame
  // Output samples
  output logic                                 m_tvalid_o,
  input  wire logic                            m_tready_i,
  // luma, blue_diff, red_diff, block_column, block_row, sample_index, zero pad
  output logic [ybf_pkg::OUT_DATA_W-1:0]       m_tdata_o,
  output logic                                 m_tlast_o,  // last_in_block
  output logic                                 m_tuser_o,  // last_in_frame
  // Configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [ybf_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [ybf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ybf_pkg::cmd_t cmd;
  ybf_pkg::sts_t sts;

  ybf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ybf_datapath #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o)
  );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for ycbcr_8x8_block_former_core: random RGB pixel streams
// with random stalls on both sides, checked sample by sample against a tiling model.
// Depends on ybf_pkg and the block former RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int          MAX_W         = 2048;
  localparam int          MAX_H         = 4096;
  localparam int          CLK_PERIOD    = 4;
  localparam int          RESET_CYCLES  = 9;
  localparam int unsigned MAX_GAP       = 13;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS  = 130;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // One YCbCr sample of an emitted block
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic [7:0] block_column;
    logic [8:0] block_row;
    logic [5:0] sample_index;
    logic       last_in_block;
    logic       last_in_frame;
  } sample_t;

  // Tiling model: converts pixels, keeps its own band store and emits expected blocks
  class block_tiler_model;
    sample_t                              pending_samples[$];
    logic [23:0]                          band [0:8*MAX_W-1];
    int unsigned                          col_cnt;
    int unsigned                          row_cnt;
    logic [ybf_pkg::WIDTH_REG_W-1:0]      width_reg;
    logic [ybf_pkg::HEIGHT_REG_W-1:0]     height_reg;
    int                                   errors;

    function new();
      foreach (band[i]) band[i] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      width_reg  = ybf_pkg::WIDTH_RESET;
      height_reg = ybf_pkg::HEIGHT_RESET;
      errors     = 0;
    endfunction

    function void write_reg(logic [ybf_pkg::CFG_INDEX_W-1:0] idx,
                            logic [ybf_pkg::CFG_DATA_W-1:0] data);
      if (idx == ybf_pkg::REG_IMAGE_WIDTH) width_reg = data[ybf_pkg::WIDTH_REG_W-1:0];
      else if (idx == ybf_pkg::REG_IMAGE_HEIGHT) height_reg = data[ybf_pkg::HEIGHT_REG_W-1:0];
    endfunction

    // Zero counts as one, oversize saturates
    function int unsigned clamp_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned cur_width();
      return clamp_size(width_reg, MAX_W);
    endfunction

    function int unsigned cur_height();
      return clamp_size(height_reg, MAX_H);
    endfunction

    function logic [7:0] to_byte(int acc);
      if (acc < 0) return 8'd0;
      acc = acc >>> 16;
      if (acc > 255) return 8'd255;
      return acc[7:0];
    endfunction

    // JFIF conversion, 16 fraction bits
    function logic [23:0] ycbcr(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int ri, gi, bi;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      return {to_byte(19595 * ri + 38470 * gi + 7471 * bi),
              to_byte(-11056 * ri - 21712 * gi + 32768 * bi + (128 << 16)),
              to_byte(32768 * ri - 27440 * gi - 5328 * bi + (128 << 16))};
    endfunction

    // Store one accepted pixel; queue a whole block when it completes one
    function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic sof);
      int unsigned w, h, c, rw, off, bcol, brow, col, rowp;
      logic        last_col, last_row;
      logic [23:0] v;
      sample_t     s;
      w = cur_width();
      h = cur_height();
      if (sof) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      c   = col_cnt;
      rw  = row_cnt;
      off = rw % 8;
      if (c < MAX_W) band[off * MAX_W + c] = ycbcr(r, g, b);
      last_col = (c >= w - 1);
      last_row = (rw >= h - 1);
      if ((last_col || c % 8 == 7) && (last_row || off == 7)) begin
        bcol = c / 8;
        brow = rw / 8;
        for (int m = 0; m < 8; m++) begin
          for (int n = 0; n < 8; n++) begin
            col  = bcol * 8 + n;
            rowp = brow * 8 + m;
            v = (m <= off && rowp < h && col < w && col < MAX_W) ? band[m * MAX_W + col] : '0;
            s.luma          = v[23:16];
            s.blue_diff     = v[15:8];
            s.red_diff      = v[7:0];
            s.block_column  = 8'(bcol);
            s.block_row     = 9'(brow);
            s.sample_index  = 6'(m * 8 + n);
            s.last_in_block = (s.sample_index == ybf_pkg::LAST_SAMPLE);
            s.last_in_frame = s.last_in_block && last_col && last_row;
            pending_samples.push_back(s);
          end
        end
      end
      if (last_col) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : rw + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one accepted output item with the oldest expected sample
    function void check_sample(logic [ybf_pkg::OUT_DATA_W-1:0] data, logic tlast, logic tuser);
      sample_t want;
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample, expected none, actual tdata %h tlast %b tuser %b",
                 $time, data, tlast, tuser);
        return;
      end
      want = pending_samples.pop_front();
      compare_field("luma", want.luma, data[7:0]);
      compare_field("blue_diff", want.blue_diff, data[15:8]);
      compare_field("red_diff", want.red_diff, data[23:16]);
      compare_field("block_column", want.block_column, data[31:24]);
      compare_field("block_row", want.block_row, data[40:32]);
      compare_field("sample_index", want.sample_index, data[46:41]);
      compare_field("last_in_block", want.last_in_block, tlast);
      compare_field("last_in_frame", want.last_in_frame, tuser);
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic                                 clk_i    = 1'b0;
  logic                                 rst_ni   = 1'b0;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready_o;
  logic [ybf_pkg::IN_DATA_W-1:0]        s_tdata  = '0;  // red, green, blue
  logic                                 s_tuser  = 1'b0; // start_of_frame
  logic                                 m_tvalid_o;
  logic                                 m_tready = 1'b0;
  logic [ybf_pkg::OUT_DATA_W-1:0]       m_tdata_o;
  logic                                 m_tlast_o;
  logic                                 m_tuser_o;
  logic                                 cfg_we    = 1'b0;
  logic [ybf_pkg::CFG_INDEX_W-1:0]      cfg_index = '0;
  logic [ybf_pkg::CFG_DATA_W-1:0]       cfg_data  = '0;

  bit                                   src_steady  = 1'b0;
  bit                                   sink_steady = 1'b0;
  int unsigned                          cycles = 0;

  block_tiler_model tiler = new();

  ycbcr_8x8_block_former_core #(
    .MAX_IMAGE_WIDTH (MAX_W),
    .MAX_IMAGE_HEIGHT(MAX_H)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Handshake monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready_o)
        tiler.take_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tuser);
      if (m_tvalid_o && m_tready)
        tiler.check_sample(m_tdata_o, m_tlast_o, m_tuser_o);
    end
  end

  // Idle cycles before the next item; flips now and then into gap-free stretches
  function automatic int unsigned draw_gap(inout bit steady);
    if ($urandom_range(0, 15) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Output side: random back-pressure per item
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = draw_gap(sink_steady);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (m_tvalid_o !== 1'b1);
    end
  end

  // Send one pixel; entered and left at a falling edge
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic sof);
    int unsigned gap;
    gap = draw_gap(src_steady);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata  <= {b, g, r};
    s_tuser  <= sof;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_tready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic send_random_pixel(input logic sof);
    send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), sof);
  endtask

  // Wait until every expected sample is out and the pixel pipeline has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tiler.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ybf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ybf_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    tiler.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent, count, frame, old_w, new_w, new_h;
    bit          write_w, write_h, restart;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero sizes act as 1x1: every pixel is a block, component extremes, frame wrap
    write_reg(ybf_pkg::REG_IMAGE_WIDTH, 13'd0);
    write_reg(ybf_pkg::REG_IMAGE_HEIGHT, 13'd0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    settle();

    // Oversize width (upper data bit dropped, then saturated), one-row image,
    // restart in the middle of the frame
    write_reg(ybf_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(ybf_pkg::REG_IMAGE_HEIGHT, 13'd1);
    send_random_pixel(1'b1);
    repeat (2) send_random_pixel(1'b0);
    send_random_pixel(1'b1);
    repeat (7) send_random_pixel(1'b0);
    settle();

    // Shrink the width below the current column and resize height mid-frame
    write_reg(ybf_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(ybf_pkg::REG_IMAGE_WIDTH, 13'd8);
    send_random_pixel(1'b0);
    settle();
    write_reg(ybf_pkg::REG_IMAGE_HEIGHT, 13'd2);
    repeat (8) send_random_pixel(1'b0);

    // Random phases: mostly whole small frames, some partial ones and stray restarts
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      old_w = tiler.cur_width();
      case ($urandom_range(0, 15))
        0:       new_w = 0;
        1:       new_w = MAX_W;
        2:       new_w = 4095;
        default: new_w = $urandom_range(1, 20);
      endcase
      case ($urandom_range(0, 15))
        0:       new_h = 0;
        1:       new_h = MAX_H;
        2:       new_h = 8191;
        default: new_h = $urandom_range(1, 12);
      endcase
      // bit 12 is beyond the width register and must be dropped
      new_w   = new_w | ($urandom_range(0, 1) << 12);
      write_w = ($urandom_range(0, 3) != 0);
      write_h = ($urandom_range(0, 3) != 0);
      if (!write_w && !write_h) write_w = 1'b1;
      if (write_w) write_reg(ybf_pkg::REG_IMAGE_WIDTH, 13'(new_w));
      if (write_h) write_reg(ybf_pkg::REG_IMAGE_HEIGHT, 13'(new_h));

      // A wider image must restart, so no never-written band entry is read
      restart = (tiler.cur_width() > old_w) || ($urandom_range(0, 3) == 0);
      frame   = tiler.cur_width() * tiler.cur_height();
      count   = (frame <= 48) ? frame * $urandom_range(1, 2) : $urandom_range(16, 48);
      for (int i = 0; i < count; i++)
        send_random_pixel((i == 0 && restart) || ($urandom_range(0, 39) == 0));
      sent += count;
    end

    settle();
    if (tiler.errors == 0 && tiler.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ybf_pkg.sv
rtl/core/ybf_ctrl.sv
rtl/core/ybf_datapath.sv
rtl/core/ycbcr_8x8_block_former_core.sv
dv/testbench.sv
